>>> rtl/core/jmcf_pkg.sv
// ----------------------------------------------------------------------------
// jmcf_pkg
// Types, constants and the CRC step shared by the motor command framer.
// ----------------------------------------------------------------------------
package jmcf_pkg;

	localparam int AXIS_W    = 16;
	localparam int MAG_W     = 15;
	localparam int SPEED_W   = 8;
	localparam int SMAG_W    = 7;
	localparam int WEIGHT_W  = 9;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 15;

	localparam logic [15:0] CRC_POLY   = 16'h1021;
	localparam logic [8:0]  WEIGHT_ONE = 9'd256;

	// scaling: round-half-away(mag * 127 / 32767) = floor((254*mag + 32767) / 65534)
	localparam logic [22:0] SCALE_BIAS = 23'd32767;
	localparam logic [22:0] SCALE_DIV  = 23'd65534;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ADDRESS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_BAND = 2'd3;

	localparam logic [7:0] RST_ADDRESS   = 8'd128;
	localparam logic [8:0] RST_WEIGHT    = 9'd51;
	localparam logic [14:0] RST_DEAD_BAND = 15'd1638;
	localparam logic [6:0] RST_STOP_BAND = 7'd5;

	// direction commands
	localparam logic [7:0] CMD_FIRST_FWD  = 8'h00;
	localparam logic [7:0] CMD_FIRST_REV  = 8'h01;
	localparam logic [7:0] CMD_SECOND_FWD = 8'h04;
	localparam logic [7:0] CMD_SECOND_REV = 8'h05;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef struct packed {
		logic [7:0]          address;
		logic [WEIGHT_W-1:0] weight;
		logic [MAG_W-1:0]    dead_band;
		logic [SMAG_W-1:0]   stop_band;
	} cfg_t;

	// one packet to be sent
	typedef struct packed {
		logic [7:0]        cmd;
		logic [SMAG_W-1:0] mag;
		logic              run_end;
	} desc_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_DEAD,
		F_SCALE,
		F_BLEND,
		F_KEEP,
		F_PUSH
	} fe_state_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int b = 0; b < 8; b++) begin
			if (c[15])
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			else
				c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

>>> rtl/core/jmcf_queue.sv
// ----------------------------------------------------------------------------
// jmcf_queue
// Small packet descriptor FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module jmcf_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jmcf_pkg::desc_t  push_data,
	output logic             full,
	input  logic             pop,
	output jmcf_pkg::desc_t  pop_data,
	output logic             empty
);
	import jmcf_pkg::*;

	desc_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> rtl/core/jmcf_front.sv
// ----------------------------------------------------------------------------
// jmcf_front
// Accepts requests, computes the smoothed speeds and queues packet
// descriptors.
// ----------------------------------------------------------------------------
module jmcf_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  jmcf_pkg::cfg_t                cfg,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [2*jmcf_pkg::AXIS_W-1:0] s_tdata,  // axis_first, axis_second
	input  logic                          s_tuser,  // kind
	output logic                          push,
	output jmcf_pkg::desc_t               push_data,
	input  logic                          full
);
	import jmcf_pkg::*;

	fe_state_t               state_q;
	fe_state_t               state_d;
	logic                    kind_q;
	logic [AXIS_W-1:0]       axis_q   [2];
	logic [22:0]             num_s1   [2];
	logic                    neg_s1   [2];
	logic signed [SPEED_W-1:0] target_s2 [2];
	logic signed [17:0]      sum_s3   [2];
	logic signed [SPEED_W-1:0] speed_q  [2];
	logic [1:0]              cnt_q;
	logic                    accept;
	logic                    push_last;

	logic [22:0]             num_d    [2];
	logic                    neg_d    [2];
	logic signed [SPEED_W-1:0] target_d [2];
	logic signed [17:0]      sum_d    [2];
	logic signed [SPEED_W-1:0] speed_d  [2];
	logic [WEIGHT_W-1:0]     w_eff;

	assign accept    = s_tvalid && s_tready;
	assign push_last = kind_q ? (cnt_q == 2'd3) : (cnt_q == 2'd1);

	// lane arithmetic
	always_comb begin
		logic signed [AXIS_W-1:0] ax;
		logic [AXIS_W-1:0]        mag16;
		logic [MAG_W-1:0]         mag;
		logic [6:0]               q_est;
		logic [22:0]              rem;
		logic [6:0]               q;
		logic signed [9:0]        ws;
		logic signed [9:0]        wi;
		logic signed [17:0]       p_new;
		logic signed [17:0]       p_old;
		logic [17:0]              abs_sum;
		logic [15:0]              rounded;
		logic [SMAG_W-1:0]        kept;
		w_eff = (cfg.weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.weight;
		ws    = $signed({1'b0, w_eff});
		wi    = $signed({1'b0, WEIGHT_ONE - w_eff});
		for (int l = 0; l < 2; l++) begin
			ax = $signed(axis_q[l]);
			if (ax == 16'sh8000)
				ax = 16'sh8001;
			neg_d[l] = ax[AXIS_W-1];
			mag16    = neg_d[l] ? 16'(-ax) : 16'(ax);
			mag      = mag16[MAG_W-1:0];
			if (mag < cfg.dead_band)
				mag = '0;
			num_d[l] = ({mag, 8'b0} - {7'b0, mag, 1'b0}) + SCALE_BIAS;

			q_est = num_s1[l][22:16];
			rem   = num_s1[l] - ({q_est, 16'b0} - {15'b0, q_est, 1'b0});
			q     = (rem >= SCALE_DIV) ? q_est + 1'b1 : q_est;
			target_d[l] = neg_s1[l] ? -$signed({1'b0, q}) : $signed({1'b0, q});

			p_new    = 18'(ws) * 18'(target_s2[l]);
			p_old    = 18'(wi) * 18'(speed_q[l]);
			sum_d[l] = p_new + p_old;

			abs_sum = sum_s3[l][17] ? 18'(-sum_s3[l]) : 18'(sum_s3[l]);
			rounded = abs_sum[15:0] + 16'd128;
			kept    = rounded[14:8];
			if (kept <= cfg.stop_band)
				kept = '0;
			speed_d[l] = sum_s3[l][17] ? -$signed({1'b0, kept}) : $signed({1'b0, kept});
		end
	end

	// next state and descriptor
	always_comb begin
		logic              rev;
		logic              second;
		logic [SPEED_W-1:0] sp;
		state_d   = state_q;
		s_tready  = 1'b0;
		push      = 1'b0;
		rev       = 1'b0;
		second    = 1'b0;
		sp        = '0;
		push_data = '0;
		case (state_q)
			F_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = s_tuser ? F_PUSH : F_DEAD;
			end
			F_DEAD:  state_d = F_SCALE;
			F_SCALE: state_d = F_BLEND;
			F_BLEND: state_d = F_KEEP;
			F_KEEP:  state_d = F_PUSH;
			F_PUSH: begin
				push = 1'b1;
				if (!full && push_last)
					state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
		if (kind_q) begin
			second = cnt_q[1];
			rev    = cnt_q[0];
		end else begin
			second = cnt_q[0];
			sp     = speed_q[cnt_q[0]];
			rev    = sp[SPEED_W-1];
			sp     = rev ? SPEED_W'(-$signed(sp)) : sp;
		end
		case ({second, rev})
			2'b00:   push_data.cmd = CMD_FIRST_FWD;
			2'b01:   push_data.cmd = CMD_FIRST_REV;
			2'b10:   push_data.cmd = CMD_SECOND_FWD;
			default: push_data.cmd = CMD_SECOND_REV;
		endcase
		push_data.mag     = sp[SMAG_W-1:0];
		push_data.run_end = push_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_IDLE;
			cnt_q      <= '0;
			speed_q[0] <= '0;
			speed_q[1] <= '0;
		end else begin
			state_q <= state_d;
			if (accept)
				cnt_q <= '0;
			else if (push && !full)
				cnt_q <= cnt_q + 1'b1;
			if (state_q == F_KEEP) begin
				speed_q[0] <= speed_d[0];
				speed_q[1] <= speed_d[1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q    <= s_tuser;
			axis_q[0] <= s_tdata[AXIS_W-1:0];
			axis_q[1] <= s_tdata[2*AXIS_W-1:AXIS_W];
		end
		for (int l = 0; l < 2; l++) begin
			num_s1[l]    <= num_d[l];
			neg_s1[l]    <= neg_d[l];
			target_s2[l] <= target_d[l];
			sum_s3[l]    <= sum_d[l];
		end
	end

endmodule

>>> rtl/core/jmcf_back.sv
// ----------------------------------------------------------------------------
// jmcf_back
// Serialises queued descriptors into five-byte packets with CRC-16/XMODEM.
// ----------------------------------------------------------------------------
module jmcf_back (
	input  logic            clk,
	input  logic            arst_n,
	input  jmcf_pkg::cfg_t  cfg,
	output logic            pop,
	input  jmcf_pkg::desc_t pop_data,
	input  logic            empty,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [7:0]      m_tdata,  // tx_byte
	output logic            m_tlast,  // last
	output logic            m_tuser   // packet_end
);
	import jmcf_pkg::*;

	localparam logic [2:0] BYTE_LAST = 3'd4;

	desc_t       desc_q;
	logic        busy_q;
	logic [2:0]  idx_q;
	logic [15:0] crc_q;
	logic        valid_q;
	logic [7:0]  data_q;
	logic        last_q;
	logic        end_q;
	logic        advance;
	logic [7:0]  byte_d;

	assign advance  = busy_q && (!valid_q || m_tready);
	assign pop      = !empty && (!busy_q || (advance && idx_q == BYTE_LAST));
	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;
	assign m_tuser  = end_q;

	always_comb begin
		case (idx_q)
			3'd0:    byte_d = cfg.address;
			3'd1:    byte_d = desc_q.cmd;
			3'd2:    byte_d = {1'b0, desc_q.mag};
			3'd3:    byte_d = crc_q[15:8];
			default: byte_d = crc_q[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (advance) begin
				if (idx_q == BYTE_LAST)
					busy_q <= 1'b0;
				idx_q <= idx_q + 1'b1;
			end
			if (advance)
				valid_q <= 1'b1;
			else if (m_tready)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			desc_q <= pop_data;
		if (advance) begin
			data_q <= byte_d;
			end_q  <= (idx_q == BYTE_LAST);
			last_q <= (idx_q == BYTE_LAST) && desc_q.run_end;
			if (idx_q < 3'd3)
				crc_q <= crc_byte((idx_q == 3'd0) ? 16'h0000 : crc_q, byte_d);
		end
	end

endmodule

>>> rtl/core/joystick_motor_command_framer_core.sv
// ----------------------------------------------------------------------------
// joystick_motor_command_framer_core
// Turns joystick requests into pairs of motor command packets, or four
// zero-speed packets for a stop request.
//
//  channel | dir | payload
//  s_*     | in  | tdata {axis_second, axis_first}, tuser kind
//  m_*     | out | tdata tx_byte, tuser packet_end, tlast last
//  cfg_*   | in  | cfg_index register, cfg_data value (always ready)
//
// A sample request yields ten bytes, a stop request twenty; the byte
// serialiser (one byte per cycle while m_tready is high) sets the rate. The
// front end takes no new request until it has queued the last one's
// descriptors, and runs ahead through a 4-entry descriptor queue.
// Reset clears speeds and queue and restores register defaults; output
// stalls hold the byte.
// ----------------------------------------------------------------------------
module joystick_motor_command_framer_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [31:0]                       s_tdata,   // axis_first, axis_second
	input  logic                              s_tuser,   // kind
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [7:0]                        m_tdata,   // tx_byte
	output logic                              m_tuser,   // packet_end
	output logic                              m_tlast,   // last
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [jmcf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [jmcf_pkg::CFG_DAT_W-1:0]    cfg_data
);
	import jmcf_pkg::*;

	cfg_t  cfg_q;
	logic  q_push;
	desc_t q_push_data;
	logic  q_full;
	logic  q_pop;
	desc_t q_pop_data;
	logic  q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.address   <= RST_ADDRESS;
			cfg_q.weight    <= RST_WEIGHT;
			cfg_q.dead_band <= RST_DEAD_BAND;
			cfg_q.stop_band <= RST_STOP_BAND;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ADDRESS:   cfg_q.address   <= cfg_data[7:0];
				REG_WEIGHT:    cfg_q.weight    <= cfg_data[WEIGHT_W-1:0];
				REG_DEAD_BAND: cfg_q.dead_band <= cfg_data[MAG_W-1:0];
				REG_STOP_BAND: cfg_q.stop_band <= cfg_data[SMAG_W-1:0];
				default: ;
			endcase
		end
	end

	jmcf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full)
	);

	jmcf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.empty     (q_empty)
	);

	jmcf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.pop      (q_pop),
		.pop_data (q_pop_data),
		.empty    (q_empty),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks joystick_motor_command_framer_core against a predictor of the
// smoothing, direction and CRC-16/XMODEM packet logic. Directed requests
// cover the axis extremes, dead-band edges and stop requests; random
// requests follow under several register settings, with random idling on
// both streams. Every sent byte is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module testbench;

	import jmcf_pkg::*;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       pkt_end;
		logic       run_last;
	} tx_beat_t;

	class command_byte_board;
		tx_beat_t   pending_bytes[$];
		logic [7:0] address;
		int         weight;
		int         dead_band;
		int         stop_band;
		int         speed_first;
		int         speed_second;
		int         mismatches;

		function new();
			address      = RST_ADDRESS;
			weight       = int'(RST_WEIGHT);
			dead_band    = int'(RST_DEAD_BAND);
			stop_band    = int'(RST_STOP_BAND);
			speed_first  = 0;
			speed_second = 0;
			mismatches   = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
				REG_ADDRESS:   address   = data[7:0];
				REG_WEIGHT:    weight    = int'(data[WEIGHT_W-1:0]);
				REG_DEAD_BAND: dead_band = int'(data[MAG_W-1:0]);
				REG_STOP_BAND: stop_band = int'(data[SMAG_W-1:0]);
				default: ;
			endcase
		endfunction

		// dead band, scale to -127..127, blend with the kept speed, stop band
		function int blend_axis(logic [15:0] raw, int prev);
			int  a;
			int  mag;
			int  target;
			int  w;
			int  sum;
			int  kept;
			bit  neg;
			a = int'($signed(raw));
			if (a < -32767)
				a = -32767;
			neg = a < 0;
			mag = neg ? -a : a;
			if (mag < dead_band)
				mag = 0;
			target = (2 * mag * 127 + 32767) / 65534;
			if (neg)
				target = -target;
			w    = (weight > 256) ? 256 : weight;
			sum  = w * target + (256 - w) * prev;
			neg  = sum < 0;
			mag  = neg ? -sum : sum;
			kept = (mag + 128) / 256;
			if (kept <= stop_band)
				kept = 0;
			return neg ? -kept : kept;
		endfunction

		function void push_packet(logic [7:0] cmd, int mag, bit run_last);
			logic [7:0]  body[3];
			logic [15:0] crc;
			tx_beat_t    beat;
			body[0] = address;
			body[1] = cmd;
			body[2] = mag[7:0];
			crc = 16'h0000;
			foreach (body[i]) begin
				crc[15:8] = crc[15:8] ^ body[i];
				repeat (8) begin
					if (crc[15])
						crc = (crc << 1) ^ 16'h1021;
					else
						crc = crc << 1;
				end
			end
			for (int i = 0; i < 5; i++) begin
				beat.tx_byte  = (i < 3) ? body[i] : ((i == 3) ? crc[15:8] : crc[7:0]);
				beat.pkt_end  = (i == 4);
				beat.run_last = (i == 4) && run_last;
				pending_bytes = {pending_bytes, beat};
			end
		endfunction

		function void note_request(logic kind, logic [31:0] data);
			if (kind) begin
				push_packet(CMD_FIRST_FWD, 0, 1'b0);
				push_packet(CMD_FIRST_REV, 0, 1'b0);
				push_packet(CMD_SECOND_FWD, 0, 1'b0);
				push_packet(CMD_SECOND_REV, 0, 1'b1);
			end else begin
				speed_first  = blend_axis(data[15:0], speed_first);
				speed_second = blend_axis(data[31:16], speed_second);
				if (speed_first >= 0)
					push_packet(CMD_FIRST_FWD, speed_first, 1'b0);
				else
					push_packet(CMD_FIRST_REV, -speed_first, 1'b0);
				if (speed_second >= 0)
					push_packet(CMD_SECOND_FWD, speed_second, 1'b1);
				else
					push_packet(CMD_SECOND_REV, -speed_second, 1'b1);
			end
		endfunction

		function void check_byte(logic [7:0] tx_byte, logic pkt_end, logic run_last);
			tx_beat_t want;
			if (pending_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected byte %02h end %b last %b", tx_byte, pkt_end,
						run_last);
				return;
			end
			want = pending_bytes.pop_front();
			if (want.tx_byte !== tx_byte || want.pkt_end !== pkt_end ||
					want.run_last !== run_last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("byte mismatch: expected %02h end %b last %b, got %02h end %b last %b",
						want.tx_byte, want.pkt_end, want.run_last, tx_byte, pkt_end,
						run_last);
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [31:0]          s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [7:0]           m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	command_byte_board board = new();
	bit                steady = 1'b0;

	joystick_motor_command_framer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 30);
		if (arst_n && m_tvalid && m_tready)
			board.check_byte(m_tdata, m_tuser, m_tlast);
	end

	task automatic send_request(input logic kind, input logic [15:0] first,
			input logic [15:0] second);
		while (!steady && $urandom_range(99) < 30) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {second, first};
		do @(posedge clk); while (!s_tready);
		board.note_request(kind, {second, first});
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, data);
	endtask

	task automatic write_config(input int addr, input int w, input int dead, input int stop);
		write_reg(REG_ADDRESS, CFG_DAT_W'(addr));
		write_reg(REG_WEIGHT, CFG_DAT_W'(w));
		write_reg(REG_DEAD_BAND, CFG_DAT_W'(dead));
		write_reg(REG_STOP_BAND, CFG_DAT_W'(stop));
		cfg_valid <= 1'b0;
	endtask

	// hold the sender off until every byte is out, then let the front end settle
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (board.pending_bytes.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_axis(int dead);
		int v;
		case ($urandom_range(9))
			0, 1, 2, 3: v = int'($signed(16'($urandom)));
			4, 5: begin
				v = dead + $urandom_range(4) - 2;
				if ($urandom_range(1))
					v = -v;
			end
			6: v = $urandom_range(1) ? 32767 : -32768;
			default: v = $urandom_range(24000) - 12000;
		endcase
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	task automatic run_random(input int count, input int calm_from, input int calm_to,
			input int pause_at);
		for (int i = 0; i < count; i++) begin
			if (i == pause_at)
				wait_drained();
			steady = (i >= calm_from) && (i < calm_to);
			send_request($urandom_range(9) == 0, pick_axis(board.dead_band),
				pick_axis(board.dead_band));
		end
		steady = 1'b0;
	endtask

	initial begin
		#2_000_000;
		$display("joystick_motor_command_framer_core verification failed");
		$finish;
	end

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= 1'b0;
		m_tready  <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: extremes, dead-band edges, stop requests
		send_request(1'b0, 16'sd0, 16'sd0);
		send_request(1'b0, 16'sd32767, -16'sd32768);
		send_request(1'b0, -16'sd32768, 16'sd32767);
		send_request(1'b0, 16'sd1638, -16'sd1638);
		send_request(1'b0, 16'sd1637, -16'sd1637);
		send_request(1'b1, 16'($urandom), 16'($urandom));
		for (int i = 0; i < 6; i++)
			send_request(1'b0, 16'sd32767, -16'sd32768);
		send_request(1'b1, 16'hFFFF, 16'h8000);
		send_request(1'b0, 16'sd0, 16'sd0);
		run_random(70, 100, 100, 35);
		wait_drained();

		// full weight, no bands, address zero
		write_config(0, 256, 0, 0);
		send_request(1'b0, 16'sd32767, -16'sd32767);
		send_request(1'b0, 16'sd1, -16'sd1);
		send_request(1'b0, 16'sd129, -16'sd129);
		send_request(1'b0, 16'sd387, -16'sd387);
		send_request(1'b1, 16'sd0, 16'sd0);
		run_random(70, 100, 100, -1);
		wait_drained();

		// no weight, widest bands: targets ignored and all speeds forced to zero
		write_config(255, 0, 32767, 127);
		send_request(1'b0, 16'sd32767, -16'sd32767);
		send_request(1'b0, -16'sd32768, 16'sd32766);
		run_random(40, 100, 100, -1);
		wait_drained();

		// weight above one, acting as one
		write_config($urandom_range(255), 511, $urandom_range(4000), $urandom_range(20));
		run_random(70, 20, 60, -1);
		wait_drained();

		write_config($urandom_range(255), 300, $urandom_range(2000), $urandom_range(10));
		run_random(50, 100, 100, -1);
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			write_config($urandom_range(255), $urandom_range(511),
				($urandom_range(3) == 0) ? $urandom_range(32767) : $urandom_range(3000),
				$urandom_range(3) == 0 ? $urandom_range(127) : $urandom_range(15));
			run_random(45, 100, 100, -1);
			wait_drained();
		end

		if (board.mismatches == 0 && board.pending_bytes.size() == 0)
			$display("joystick_motor_command_framer_core verification clean");
		else
			$display("joystick_motor_command_framer_core verification failed");
		$finish;
	end

endmodule
